### rtl/tpsd_pkg.sv
// Package for the three-position switch debouncer: phase and position codes,
// register map, reset values and widths. No dependencies.
`default_nettype none

package tpsd_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int MV_WIDTH   = 12;
    localparam int DEB_WIDTH  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int NUM_REGS   = 6;
    localparam int ADDR_WIDTH = $clog2(NUM_REGS * 4);
    localparam int IDX_WIDTH  = ADDR_WIDTH - 2;

    typedef enum logic [2:0] {
        PH_NEUTRAL      = 3'd0,
        PH_CONF_BACK    = 3'd1,
        PH_BACK         = 3'd2,
        PH_CONF_FRONT   = 3'd3,
        PH_FRONT        = 3'd4,
        PH_CONF_NEUTRAL = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        POS_NEUTRAL = 2'd0,
        POS_BACK    = 2'd1,
        POS_FRONT   = 2'd2
    } t_pos;

    typedef enum logic [IDX_WIDTH-1:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_BACK_LOW   = 3'd1,
        REG_BACK_HIGH  = 3'd2,
        REG_FRONT_LOW  = 3'd3,
        REG_FRONT_HIGH = 3'd4,
        REG_IDLE_MV    = 3'd5
    } t_reg_idx;

    localparam logic [DEB_WIDTH-1:0] RST_DEBOUNCE   = 16'd100;
    localparam logic [MV_WIDTH-1:0]  RST_BACK_LOW   = 12'd775;
    localparam logic [MV_WIDTH-1:0]  RST_BACK_HIGH  = 12'd875;
    localparam logic [MV_WIDTH-1:0]  RST_FRONT_LOW  = 12'd2425;
    localparam logic [MV_WIDTH-1:0]  RST_FRONT_HIGH = 12'd2525;
    localparam logic [MV_WIDTH-1:0]  RST_IDLE_MV    = 12'd1650;

    // Stable phase of a position.
    function automatic logic [2:0] stable_of(input logic [1:0] pos);
        logic [2:0] ph;
        unique case (pos)
            POS_NEUTRAL: ph = PH_NEUTRAL;
            POS_BACK:    ph = PH_BACK;
            default:     ph = PH_FRONT;
        endcase
        return ph;
    endfunction

    // Confirm phase of a candidate position.
    function automatic logic [2:0] confirm_of(input logic [1:0] pos);
        logic [2:0] ph;
        unique case (pos)
            POS_NEUTRAL: ph = PH_CONF_NEUTRAL;
            POS_BACK:    ph = PH_CONF_BACK;
            default:     ph = PH_CONF_FRONT;
        endcase
        return ph;
    endfunction

endpackage

`default_nettype wire

### rtl/tpsd_if.sv
// Valid/ready channel interfaces for the switch debouncer: sample input and
// position result. Depends on tpsd_pkg for field widths.
`default_nettype none

interface tpsd_in_if;
    logic                             valid;
    logic                             ready;
    logic [tpsd_pkg::MV_WIDTH-1:0]    sample_mv;
    logic                             sense_enable;
    logic [tpsd_pkg::TIME_WIDTH-1:0]  now_ms;

    modport source (output valid, sample_mv, sense_enable, now_ms, input ready);
    modport sink   (input valid, sample_mv, sense_enable, now_ms, output ready);
endinterface

interface tpsd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] position;
    logic [2:0] phase;

    modport source (output valid, position, phase, input ready);
    modport sink   (input valid, position, phase, output ready);
endinterface

`default_nettype wire

### rtl/three_position_switch_debouncer.sv
// Latency: a result is valid in the cycle after its sample transaction is accepted.
// One sample per cycle while the result is taken; a stalled result blocks samples.
// The rate is set by one 32-bit add and compare plus the phase logic per sample.
// Reset (synchronous, active low) sets neutral phase and position, start time 0,
// and the register defaults. Depends on tpsd_pkg and tpsd_if.
`default_nettype none

module three_position_switch_debouncer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    tpsd_in_if.sink                                 i_in,
    tpsd_out_if.source                              o_out,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tpsd_pkg::ADDR_WIDTH-1:0]    paddr,
    input  wire logic [tpsd_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic      [tpsd_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                                    pready
);

    // Configuration registers.
    logic [tpsd_pkg::DEB_WIDTH-1:0] r_debounce;
    logic [tpsd_pkg::MV_WIDTH-1:0]  r_back_low;
    logic [tpsd_pkg::MV_WIDTH-1:0]  r_back_high;
    logic [tpsd_pkg::MV_WIDTH-1:0]  r_front_low;
    logic [tpsd_pkg::MV_WIDTH-1:0]  r_front_high;
    logic [tpsd_pkg::MV_WIDTH-1:0]  r_idle_mv;

    // Machine state. The state registers double as the result register: they
    // change only when a sample is accepted, which happens only while the
    // result slot is empty or being emptied.
    logic [2:0]                      r_phase, n_phase;
    logic [1:0]                      r_pos, n_pos;
    logic [tpsd_pkg::TIME_WIDTH-1:0] r_start, n_start;
    logic                            r_out_valid;

    logic                            in_accept;
    logic                            cfg_write;
    logic [tpsd_pkg::IDX_WIDTH-1:0]  cfg_idx;
    logic [tpsd_pkg::MV_WIDTH-1:0]   volt;
    logic [2:0]                      seen;      // indexed by position code
    logic [tpsd_pkg::TIME_WIDTH-1:0] deadline;
    logic                            timed;
    logic [1:0]                      cand;
    logic [1:0]                      other;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[tpsd_pkg::ADDR_WIDTH-1:2];

    // APB register file. Writes outside the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= tpsd_pkg::RST_DEBOUNCE;
            r_back_low   <= tpsd_pkg::RST_BACK_LOW;
            r_back_high  <= tpsd_pkg::RST_BACK_HIGH;
            r_front_low  <= tpsd_pkg::RST_FRONT_LOW;
            r_front_high <= tpsd_pkg::RST_FRONT_HIGH;
            r_idle_mv    <= tpsd_pkg::RST_IDLE_MV;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                tpsd_pkg::REG_DEBOUNCE:   r_debounce   <= pwdata[tpsd_pkg::DEB_WIDTH-1:0];
                tpsd_pkg::REG_BACK_LOW:   r_back_low   <= pwdata[tpsd_pkg::MV_WIDTH-1:0];
                tpsd_pkg::REG_BACK_HIGH:  r_back_high  <= pwdata[tpsd_pkg::MV_WIDTH-1:0];
                tpsd_pkg::REG_FRONT_LOW:  r_front_low  <= pwdata[tpsd_pkg::MV_WIDTH-1:0];
                tpsd_pkg::REG_FRONT_HIGH: r_front_high <= pwdata[tpsd_pkg::MV_WIDTH-1:0];
                tpsd_pkg::REG_IDLE_MV:    r_idle_mv    <= pwdata[tpsd_pkg::MV_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Register readback; unused addresses read as zero.
    always_comb begin
        unique case (cfg_idx)
            tpsd_pkg::REG_DEBOUNCE:
                prdata = tpsd_pkg::DATA_WIDTH'(r_debounce);
            tpsd_pkg::REG_BACK_LOW:
                prdata = tpsd_pkg::DATA_WIDTH'(r_back_low);
            tpsd_pkg::REG_BACK_HIGH:
                prdata = tpsd_pkg::DATA_WIDTH'(r_back_high);
            tpsd_pkg::REG_FRONT_LOW:
                prdata = tpsd_pkg::DATA_WIDTH'(r_front_low);
            tpsd_pkg::REG_FRONT_HIGH:
                prdata = tpsd_pkg::DATA_WIDTH'(r_front_high);
            tpsd_pkg::REG_IDLE_MV:
                prdata = tpsd_pkg::DATA_WIDTH'(r_idle_mv);
            default:
                prdata = '0;
        endcase
    end

    // A new sample is taken whenever the result slot is empty or is being
    // drained in this same cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    // Classification. The hysteresis bands between the thresholds match no
    // class, so the machine simply holds while the voltage sits there.
    assign volt = i_in.sense_enable ? i_in.sample_mv : r_idle_mv;
    assign seen[tpsd_pkg::POS_NEUTRAL] = (volt > r_back_high) && (volt < r_front_low);
    assign seen[tpsd_pkg::POS_BACK]    = volt < r_back_low;
    assign seen[tpsd_pkg::POS_FRONT]   = volt > r_front_high;

    // The deadline wraps at the time width, just like the millisecond clock.
    assign deadline = r_start + tpsd_pkg::TIME_WIDTH'(r_debounce);
    assign timed    = i_in.now_ms > deadline;

    // Candidate of a confirm phase, and the third position that is neither the
    // confirmed one nor the candidate.
    always_comb begin
        case (r_phase)
            tpsd_pkg::PH_CONF_BACK:  cand = tpsd_pkg::POS_BACK;
            tpsd_pkg::PH_CONF_FRONT: cand = tpsd_pkg::POS_FRONT;
            default:                 cand = tpsd_pkg::POS_NEUTRAL;
        endcase
        other = 2'd3 - r_pos - cand;
    end

    // Next-state logic of the six-phase machine.
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_start = r_start;
        unique case (r_phase)
            tpsd_pkg::PH_NEUTRAL: begin
                n_pos = tpsd_pkg::POS_NEUTRAL;
                if (seen[tpsd_pkg::POS_BACK]) begin
                    n_phase = tpsd_pkg::PH_CONF_BACK;
                    n_start = i_in.now_ms;
                end else if (seen[tpsd_pkg::POS_FRONT]) begin
                    n_phase = tpsd_pkg::PH_CONF_FRONT;
                    n_start = i_in.now_ms;
                end
            end
            tpsd_pkg::PH_BACK: begin
                n_pos = tpsd_pkg::POS_BACK;
                if (seen[tpsd_pkg::POS_NEUTRAL]) begin
                    n_phase = tpsd_pkg::PH_CONF_NEUTRAL;
                    n_start = i_in.now_ms;
                end else if (seen[tpsd_pkg::POS_FRONT]) begin
                    n_phase = tpsd_pkg::PH_CONF_FRONT;
                    n_start = i_in.now_ms;
                end
            end
            tpsd_pkg::PH_FRONT: begin
                n_pos = tpsd_pkg::POS_FRONT;
                if (seen[tpsd_pkg::POS_NEUTRAL]) begin
                    n_phase = tpsd_pkg::PH_CONF_NEUTRAL;
                    n_start = i_in.now_ms;
                end else if (seen[tpsd_pkg::POS_BACK]) begin
                    n_phase = tpsd_pkg::PH_CONF_BACK;
                    n_start = i_in.now_ms;
                end
            end
            tpsd_pkg::PH_CONF_BACK, tpsd_pkg::PH_CONF_FRONT,
            tpsd_pkg::PH_CONF_NEUTRAL: begin
                // A confirm phase whose confirmed position is invalid or equals
                // its own candidate holds without change.
                if (r_pos != 2'd3 && r_pos != cand) begin
                    if (seen[r_pos]) begin
                        n_phase = tpsd_pkg::stable_of(r_pos);
                    end else if (seen[other]) begin
                        n_phase = tpsd_pkg::confirm_of(other);
                        n_start = i_in.now_ms;
                    end else if (seen[cand] && timed) begin
                        n_phase = tpsd_pkg::stable_of(cand);
                    end
                end
            end
            default: ;  // Unused phase codes hold.
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tpsd_pkg::PH_NEUTRAL;
            r_pos       <= tpsd_pkg::POS_NEUTRAL;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_start <= n_start;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.position = r_pos;
    assign o_out.phase    = r_phase;

    // A stalled result blocks new samples, so the state cannot run ahead.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("sample accepted while the result is stalled");

    // State only moves on an accepted transaction.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> ($stable(r_phase) && $stable(r_pos) && $stable(r_start)))
        else $error("debouncer state changed without a sample");

    // Passing through the back phase reports back.
    a_back_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == tpsd_pkg::PH_BACK) |=> r_pos == tpsd_pkg::POS_BACK)
        else $error("back phase did not report the back position");

    // Leaving a stable phase starts the debounce timer at the sample time.
    a_start_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_phase != r_phase
            && (r_phase == tpsd_pkg::PH_NEUTRAL || r_phase == tpsd_pkg::PH_BACK
                || r_phase == tpsd_pkg::PH_FRONT))
        |=> r_start == $past(i_in.now_ms))
        else $error("candidate start time not captured");

endmodule

`default_nettype wire

### sim/tpsd_result_checker.sv
// Result checker for the three-position switch debouncer testbench.
// Watches the sample, result and register channels, predicts every result
// and compares it. Depends on tpsd_pkg and the channel interfaces in tpsd_if.

module tpsd_result_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    tpsd_in_if                                   in_ch,
    tpsd_out_if                                  out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tpsd_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [tpsd_pkg::DATA_WIDTH-1:0] pwdata,
    input  wire logic                            pready,
    output int                                   o_mismatches,
    output int                                   o_outstanding
);

    typedef struct packed {
        logic [1:0] position;
        logic [2:0] phase;
    } t_switch_report;

    // Register copy, as written through the register port.
    logic [tpsd_pkg::DEB_WIDTH-1:0]  deb_ms;
    logic [tpsd_pkg::MV_WIDTH-1:0]   back_low_mv;
    logic [tpsd_pkg::MV_WIDTH-1:0]   back_high_mv;
    logic [tpsd_pkg::MV_WIDTH-1:0]   front_low_mv;
    logic [tpsd_pkg::MV_WIDTH-1:0]   front_high_mv;
    logic [tpsd_pkg::MV_WIDTH-1:0]   idle_mv;

    // Predicted machine state.
    logic [2:0]                      sw_phase;
    logic [1:0]                      sw_pos;
    logic [tpsd_pkg::TIME_WIDTH-1:0] cand_start;

    t_switch_report                  pending_reports[$];

    function automatic logic [2:0] hold_phase(input logic [1:0] pos);
        logic [2:0] ph;
        case (pos)
            tpsd_pkg::POS_NEUTRAL: ph = tpsd_pkg::PH_NEUTRAL;
            tpsd_pkg::POS_BACK:    ph = tpsd_pkg::PH_BACK;
            default:               ph = tpsd_pkg::PH_FRONT;
        endcase
        return ph;
    endfunction

    function automatic logic [2:0] confirm_phase(input logic [1:0] pos);
        logic [2:0] ph;
        case (pos)
            tpsd_pkg::POS_NEUTRAL: ph = tpsd_pkg::PH_CONF_NEUTRAL;
            tpsd_pkg::POS_BACK:    ph = tpsd_pkg::PH_CONF_BACK;
            default:               ph = tpsd_pkg::PH_CONF_FRONT;
        endcase
        return ph;
    endfunction

    // Advances the predicted machine by one sample and returns the report.
    function automatic t_switch_report debounce_sample(
        input logic [tpsd_pkg::MV_WIDTH-1:0]   sample_mv,
        input logic                            sense_enable,
        input logic [tpsd_pkg::TIME_WIDTH-1:0] now_ms
    );
        logic [tpsd_pkg::MV_WIDTH-1:0]   volts;
        logic [2:0]                      seen;
        logic [tpsd_pkg::TIME_WIDTH-1:0] deadline;
        logic                            timed;
        logic [1:0]                      held;
        logic [1:0]                      cand;
        logic [1:0]                      rival;
        t_switch_report                  rep;

        volts = sense_enable ? sample_mv : idle_mv;
        seen[tpsd_pkg::POS_NEUTRAL] = (volts > back_high_mv) && (volts < front_low_mv);
        seen[tpsd_pkg::POS_BACK]    = volts < back_low_mv;
        seen[tpsd_pkg::POS_FRONT]   = volts > front_high_mv;
        deadline = cand_start + tpsd_pkg::TIME_WIDTH'(deb_ms);
        timed = now_ms > deadline;

        case (sw_phase)
            tpsd_pkg::PH_NEUTRAL: begin
                sw_pos = tpsd_pkg::POS_NEUTRAL;
                if (seen[tpsd_pkg::POS_BACK]) begin
                    sw_phase = tpsd_pkg::PH_CONF_BACK;
                    cand_start = now_ms;
                end else if (seen[tpsd_pkg::POS_FRONT]) begin
                    sw_phase = tpsd_pkg::PH_CONF_FRONT;
                    cand_start = now_ms;
                end
            end
            tpsd_pkg::PH_BACK, tpsd_pkg::PH_FRONT: begin
                held = (sw_phase == tpsd_pkg::PH_BACK) ? tpsd_pkg::POS_BACK
                                                       : tpsd_pkg::POS_FRONT;
                rival = (held == tpsd_pkg::POS_BACK) ? tpsd_pkg::POS_FRONT
                                                     : tpsd_pkg::POS_BACK;
                sw_pos = held;
                if (seen[tpsd_pkg::POS_NEUTRAL]) begin
                    sw_phase = tpsd_pkg::PH_CONF_NEUTRAL;
                    cand_start = now_ms;
                end else if (seen[rival]) begin
                    sw_phase = confirm_phase(rival);
                    cand_start = now_ms;
                end
            end
            tpsd_pkg::PH_CONF_BACK, tpsd_pkg::PH_CONF_FRONT,
            tpsd_pkg::PH_CONF_NEUTRAL: begin
                cand = (sw_phase == tpsd_pkg::PH_CONF_BACK) ? tpsd_pkg::POS_BACK
                     : (sw_phase == tpsd_pkg::PH_CONF_FRONT) ? tpsd_pkg::POS_FRONT
                     : tpsd_pkg::POS_NEUTRAL;
                held = sw_pos;
                // An inconsistent confirmed position freezes the machine.
                if (held <= tpsd_pkg::POS_FRONT && held != cand) begin
                    rival = 2'd3 - held - cand;
                    if (seen[held]) begin
                        sw_phase = hold_phase(held);
                    end else if (seen[rival]) begin
                        sw_phase = confirm_phase(rival);
                        cand_start = now_ms;
                    end else if (seen[cand] && timed) begin
                        sw_phase = hold_phase(cand);
                    end
                end
            end
            default: begin
            end
        endcase

        rep.position = sw_pos;
        rep.phase = sw_phase;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_switch_report want;
        t_switch_report got;

        if (!i_rst_n) begin
            deb_ms = tpsd_pkg::RST_DEBOUNCE;
            back_low_mv = tpsd_pkg::RST_BACK_LOW;
            back_high_mv = tpsd_pkg::RST_BACK_HIGH;
            front_low_mv = tpsd_pkg::RST_FRONT_LOW;
            front_high_mv = tpsd_pkg::RST_FRONT_HIGH;
            idle_mv = tpsd_pkg::RST_IDLE_MV;
            sw_phase = tpsd_pkg::PH_NEUTRAL;
            sw_pos = tpsd_pkg::POS_NEUTRAL;
            cand_start = '0;
            pending_reports.delete();
            o_mismatches = 0;
        end else begin
            // The result taken at this edge belongs to an earlier sample, so it
            // is compared before this edge's sample is predicted.
            if (out_ch.valid && out_ch.ready) begin
                got.position = out_ch.position;
                got.phase = out_ch.phase;
                if (pending_reports.size() == 0) begin
                    $error("unexpected result transaction: position %0d phase %0d",
                           got.position, got.phase);
                    o_mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    if (got.position !== want.position) begin
                        $error("position: expected %0d, actual %0d",
                               want.position, got.position);
                        o_mismatches++;
                    end
                    if (got.phase !== want.phase) begin
                        $error("phase: expected %0d, actual %0d", want.phase, got.phase);
                        o_mismatches++;
                    end
                end
            end

            // A sample taken at this edge still sees the old register values.
            if (in_ch.valid && in_ch.ready) begin
                pending_reports.push_back(
                    debounce_sample(in_ch.sample_mv, in_ch.sense_enable, in_ch.now_ms));
            end

            if (psel && penable && pwrite && pready) begin
                case (paddr[tpsd_pkg::ADDR_WIDTH-1:2])
                    tpsd_pkg::REG_DEBOUNCE:
                        deb_ms = pwdata[tpsd_pkg::DEB_WIDTH-1:0];
                    tpsd_pkg::REG_BACK_LOW:
                        back_low_mv = pwdata[tpsd_pkg::MV_WIDTH-1:0];
                    tpsd_pkg::REG_BACK_HIGH:
                        back_high_mv = pwdata[tpsd_pkg::MV_WIDTH-1:0];
                    tpsd_pkg::REG_FRONT_LOW:
                        front_low_mv = pwdata[tpsd_pkg::MV_WIDTH-1:0];
                    tpsd_pkg::REG_FRONT_HIGH:
                        front_high_mv = pwdata[tpsd_pkg::MV_WIDTH-1:0];
                    tpsd_pkg::REG_IDLE_MV:
                        idle_mv = pwdata[tpsd_pkg::MV_WIDTH-1:0];
                    default: begin
                    end
                endcase
            end
        end
        o_outstanding = pending_reports.size();
    end

endmodule

### sim/three_position_switch_debouncer_test.sv
// Top of the three-position switch debouncer testbench: clock, reset,
// register writes and sample stimulus, and the verdict. Depends on tpsd_pkg,
// tpsd_if, the debouncer RTL and tpsd_result_checker.

module three_position_switch_debouncer_test;

    // Register settings that the random part walks through.
    typedef enum int {
        SET_DEFAULT,
        SET_NO_DEBOUNCE,
        SET_LONGEST_DEBOUNCE,
        SET_LOW_THRESHOLDS,
        SET_HIGH_THRESHOLDS,
        SET_OVERLAP,
        SET_ORDERED_RANDOM,
        SET_ANY_RANDOM,
        SET_COUNT
    } t_threshold_set;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [tpsd_pkg::ADDR_WIDTH-1:0] paddr;
    logic [tpsd_pkg::DATA_WIDTH-1:0] pwdata;
    logic [tpsd_pkg::DATA_WIDTH-1:0] prdata;
    logic                            pready;

    tpsd_in_if  in_ch ();
    tpsd_out_if out_ch ();

    int mismatches;
    int outstanding;

    // Idle percentages of the sample sender and the result receiver, and the
    // count of long receiver hold-offs asked for by the stimulus.
    int send_idle_pct;
    int recv_idle_pct;
    int stall_requests;

    // Copy of the register values, used only to aim the stimulus at the
    // voltage bands and to scale time steps to the debounce time.
    logic [tpsd_pkg::DEB_WIDTH-1:0]  deb_set;
    logic [tpsd_pkg::MV_WIDTH-1:0]   back_low_set;
    logic [tpsd_pkg::MV_WIDTH-1:0]   back_high_set;
    logic [tpsd_pkg::MV_WIDTH-1:0]   front_low_set;
    logic [tpsd_pkg::MV_WIDTH-1:0]   front_high_set;
    logic [tpsd_pkg::TIME_WIDTH-1:0] clock_ms;

    three_position_switch_debouncer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tpsd_result_checker switch_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Guard against a hang: the slowest correct run is far shorter than this.
    initial begin
        #2000000;
        $display("three_position_switch_debouncer: mismatch");
        $finish;
    end

    // The result receiver. It stalls at random with the current idle
    // percentage, and when the stimulus asks for it, holds ready low for a
    // long stretch so that the result register stays full and the block
    // has to refuse samples.
    initial begin
        int stalls_served;
        int hold_left;

        stalls_served = 0;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_requests != stalls_served) begin
                stalls_served++;
                hold_left = 64;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one sample transaction and returns at the falling edge after it
    // is accepted. Valid stays high when the next sample follows without a
    // gap, so it is never lowered and raised in the same time step.
    task automatic send_sample(input logic [tpsd_pkg::MV_WIDTH-1:0]   mv,
                               input logic                            enable,
                               input logic [tpsd_pkg::TIME_WIDTH-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample_mv <= mv;
        in_ch.sense_enable <= enable;
        in_ch.now_ms <= now;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stops offering samples and waits until every predicted result has been
    // taken. The block keeps no other work in flight, so the registers may
    // then be touched.
    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // One register write: a setup phase, then an access phase that lasts
    // until pready is seen high.
    task automatic write_register(input tpsd_pkg::t_reg_idx idx,
                                  input logic [tpsd_pkg::DATA_WIDTH-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits for the block to go idle, then writes all six registers with
    // one of the settings below.
    task automatic configure_thresholds(input t_threshold_set which);
        logic [tpsd_pkg::DEB_WIDTH-1:0] deb;
        logic [tpsd_pkg::MV_WIDTH-1:0]  bl;
        logic [tpsd_pkg::MV_WIDTH-1:0]  bh;
        logic [tpsd_pkg::MV_WIDTH-1:0]  fl;
        logic [tpsd_pkg::MV_WIDTH-1:0]  fh;
        logic [tpsd_pkg::MV_WIDTH-1:0]  idle;

        deb = tpsd_pkg::RST_DEBOUNCE;
        bl = tpsd_pkg::RST_BACK_LOW;
        bh = tpsd_pkg::RST_BACK_HIGH;
        fl = tpsd_pkg::RST_FRONT_LOW;
        fh = tpsd_pkg::RST_FRONT_HIGH;
        idle = tpsd_pkg::RST_IDLE_MV;
        case (which)
            SET_NO_DEBOUNCE: deb = '0;
            SET_LONGEST_DEBOUNCE: deb = '1;
            // Every threshold at zero: no voltage reads back or neutral.
            SET_LOW_THRESHOLDS: begin
                bl = '0;
                bh = '0;
                fl = '0;
                fh = '0;
                idle = '0;
            end
            // Every threshold at full scale: no voltage reads front.
            SET_HIGH_THRESHOLDS: begin
                bl = '1;
                bh = '1;
                fl = '1;
                fh = '1;
                idle = '1;
            end
            // The bands overlap, so one voltage can read as several positions
            // and the fixed order of the checks decides.
            SET_OVERLAP: begin
                bl = 12'd3000;
                bh = 12'd500;
                fl = 12'd3500;
                fh = 12'd1000;
                idle = tpsd_pkg::MV_WIDTH'($urandom);
            end
            SET_ORDERED_RANDOM: begin
                deb = tpsd_pkg::DEB_WIDTH'($urandom_range(300));
                bl = tpsd_pkg::MV_WIDTH'($urandom_range(1500));
                bh = bl + tpsd_pkg::MV_WIDTH'($urandom_range(200));
                fl = bh + tpsd_pkg::MV_WIDTH'($urandom_range(1500));
                fh = fl + tpsd_pkg::MV_WIDTH'($urandom_range(400));
                idle = tpsd_pkg::MV_WIDTH'($urandom);
            end
            SET_ANY_RANDOM: begin
                deb = tpsd_pkg::DEB_WIDTH'($urandom);
                bl = tpsd_pkg::MV_WIDTH'($urandom);
                bh = tpsd_pkg::MV_WIDTH'($urandom);
                fl = tpsd_pkg::MV_WIDTH'($urandom);
                fh = tpsd_pkg::MV_WIDTH'($urandom);
                idle = tpsd_pkg::MV_WIDTH'($urandom);
            end
            default: begin
            end
        endcase

        settle_idle();
        write_register(tpsd_pkg::REG_DEBOUNCE, tpsd_pkg::DATA_WIDTH'(deb));
        write_register(tpsd_pkg::REG_BACK_LOW, tpsd_pkg::DATA_WIDTH'(bl));
        write_register(tpsd_pkg::REG_BACK_HIGH, tpsd_pkg::DATA_WIDTH'(bh));
        write_register(tpsd_pkg::REG_FRONT_LOW, tpsd_pkg::DATA_WIDTH'(fl));
        write_register(tpsd_pkg::REG_FRONT_HIGH, tpsd_pkg::DATA_WIDTH'(fh));
        write_register(tpsd_pkg::REG_IDLE_MV, tpsd_pkg::DATA_WIDTH'(idle));
        deb_set = deb;
        back_low_set = bl;
        back_high_set = bh;
        front_low_set = fl;
        front_high_set = fh;
    endtask

    // A voltage that reads as the given position under the current setting,
    // or any voltage when no such voltage exists.
    function automatic logic [tpsd_pkg::MV_WIDTH-1:0] pick_voltage(
        input tpsd_pkg::t_pos where
    );
        int                            lo;
        int                            hi;
        logic [tpsd_pkg::MV_WIDTH-1:0] mv;

        mv = tpsd_pkg::MV_WIDTH'($urandom);
        case (where)
            tpsd_pkg::POS_BACK: begin
                if (back_low_set != 0)
                    mv = tpsd_pkg::MV_WIDTH'($urandom_range(back_low_set - 1));
            end
            tpsd_pkg::POS_FRONT: begin
                if (front_high_set != '1)
                    mv = tpsd_pkg::MV_WIDTH'($urandom_range(4095, front_high_set + 1));
            end
            default: begin
                lo = back_high_set + 1;
                hi = front_low_set - 1;
                if (lo <= hi) mv = tpsd_pkg::MV_WIDTH'($urandom_range(hi, lo));
            end
        endcase
        return mv;
    endfunction

    // Random part: runs of samples that aim at one position, so that
    // candidates live long enough to be confirmed, with some noise and some
    // disabled samples mixed in. Time steps scale with the debounce time, and
    // now and then time jumps anywhere, which also makes it wrap.
    task automatic run_bursts(input int count);
        int                            sent;
        int                            run_len;
        tpsd_pkg::t_pos                target;
        logic [tpsd_pkg::MV_WIDTH-1:0] mv;
        logic                          enable;

        sent = 0;
        while (sent < count) begin
            target = tpsd_pkg::t_pos'($urandom_range(2));
            run_len = $urandom_range(1, 8);
            repeat (run_len) begin
                if ($urandom_range(15) == 0) begin
                    clock_ms = $urandom;
                end else begin
                    clock_ms += $urandom_range(deb_set / 2 + 3);
                end
                enable = 1'b1;
                case ($urandom_range(9))
                    0: mv = tpsd_pkg::MV_WIDTH'($urandom);
                    1: begin
                        mv = tpsd_pkg::MV_WIDTH'($urandom);
                        enable = 1'b0;
                    end
                    default: mv = pick_voltage(target);
                endcase
                send_sample(mv, enable, clock_ms);
                sent++;
            end
        end
    endtask

    initial begin
        int send_pcts[3];
        int recv_pcts[3];

        send_pcts = '{19, 79, 0};
        recv_pcts = '{79, 19, 0};

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.sample_mv = '0;
        in_ch.sense_enable = 1'b0;
        in_ch.now_ms = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_requests = 0;
        deb_set = tpsd_pkg::RST_DEBOUNCE;
        back_low_set = tpsd_pkg::RST_BACK_LOW;
        back_high_set = tpsd_pkg::RST_BACK_HIGH;
        front_low_set = tpsd_pkg::RST_FRONT_LOW;
        front_high_set = tpsd_pkg::RST_FRONT_HIGH;
        clock_ms = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, on the reset register values. It walks every phase,
        // hits each threshold but front low from both sides, checks that a
        // candidate is not confirmed at exactly start plus debounce, that
        // the deadline wraps with time, that returning to the confirmed
        // position cancels a candidate and that a third position replaces it.
        send_sample(12'd0, 1'b1, 32'd0);
        send_sample(12'd0, 1'b1, 32'd100);
        send_sample(12'd0, 1'b1, 32'd101);
        send_sample(12'd774, 1'b1, 32'd102);
        send_sample(12'd775, 1'b1, 32'd103);
        send_sample(12'd875, 1'b1, 32'd104);
        send_sample(12'hFFF, 1'b1, 32'd200);
        send_sample(12'd800, 1'b1, 32'd400);
        send_sample(12'd2526, 1'b1, 32'd401);
        send_sample(12'd2525, 1'b1, 32'd402);
        // A disabled sample reads as the idle voltage, which is neutral.
        send_sample(12'd0, 1'b0, 32'd403);
        send_sample(12'hFFF, 1'b1, 32'd404);
        send_sample(12'd876, 1'b1, 32'hFFFF_FFF0);
        send_sample(12'd2424, 1'b1, 32'h0000_0050);
        send_sample(12'd2424, 1'b1, 32'h0000_0055);
        send_sample(12'd1650, 1'b1, 32'h0000_0056);
        send_sample(12'd0, 1'b1, 32'hFFFF_FFFF);
        send_sample(12'hFFF, 1'b1, 32'd0);
        send_sample(12'd1000, 1'b1, 32'd1);
        send_sample(12'hFFF, 1'b0, 32'd2);
        send_sample(12'hAAA, 1'b1, 32'h5555_5555);
        send_sample(12'h555, 1'b1, 32'hAAAA_AAAA);

        // Random part: three idling modes, each one through every setting.
        // Every setting change first drains all results, which is also the
        // pause of the sender until nothing is expected any more.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = send_pcts[mode];
            recv_idle_pct = recv_pcts[mode];
            for (int s = 0; s < SET_COUNT; s++) begin
                configure_thresholds(t_threshold_set'(s));
                clock_ms = $urandom;
                if (s == SET_LONGEST_DEBOUNCE) stall_requests <= stall_requests + 1;
                run_bursts(40);
            end
        end

        settle_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("three_position_switch_debouncer: match");
        end else begin
            $display("three_position_switch_debouncer: mismatch");
        end
        $finish;
    end

endmodule
